// ===== sv/dstf_pkg.sv =====
// dstf_pkg: types, codes and constants of the deceptive step trap fitness unit.
// No dependencies; imported by dstf_divider, deceptive_step_trap_fitness_unit and the bench.
`default_nettype none

package dstf_pkg;

    localparam int DEF_MAX_SOLUTION_BITS = 4096;
    localparam int DEF_FRACTION_BITS     = 16;

    localparam int TRAP_W   = 5;
    localparam int OFS_W    = 4;
    localparam int STEP_W   = 5;
    localparam int SUM_W    = 17;
    localparam int FRAC_W   = 17;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    localparam logic [TRAP_W-1:0] TRAP_MAX_SIZE = 5'd16;
    localparam logic [STEP_W-1:0] STEP_MAX_SIZE = 5'd16;
    localparam logic [SUM_W-1:0]  SUM_SAT       = 17'h1FFFF;
    localparam logic [FRAC_W-1:0] FRAC_SAT      = 17'h1FFFF;

    localparam logic [TRAP_W-1:0] RST_TRAP_BITS   = 5'd5;
    localparam logic [OFS_W-1:0]  RST_STEP_OFFSET = 4'd0;
    localparam logic [STEP_W-1:0] RST_STEP_WIDTH  = 5'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRAP_BITS   = 2'd0,
        REG_STEP_OFFSET = 2'd1,
        REG_STEP_WIDTH  = 2'd2
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_LENGTH   = 2'd1,
        ST_ZERO_MAX = 2'd2
    } t_status;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [TRAP_W-1:0] clamp_1_16(input logic [TRAP_W-1:0] v);
        logic [TRAP_W-1:0] r;
        r = v;
        if (v == '0) r = TRAP_W'(1);
        else if (v > TRAP_MAX_SIZE) r = TRAP_MAX_SIZE;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/dstf_divider.sv =====
// dstf_divider: shared restoring divider, one quotient bit per cycle.
// Numerator is loaded left-aligned; i_iters sets the quotient bit count. Uses dstf_pkg.
`default_nettype none

module dstf_divider
    import dstf_pkg::*;
#(
    parameter int NUM_W = 38,
    parameter int DEN_W = 18,
    parameter int CNT_W = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [CNT_W-1:0] i_iters,
    output logic      [NUM_W-1:0] o_quot,
    output t_div_stat             o_stat
);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_sh;
    logic [DEN_W+1:0] w_diff;

    assign w_sh   = {r_rem, r_q[NUM_W-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[DEN_W+1]) begin
                r_rem <= w_diff[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[DEN_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot      = r_q;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

// ===== sv/deceptive_step_trap_fitness_unit.sv =====
// deceptive_step_trap_fitness_unit: bit-serial step trap scoring with final normalization.
// Sequencer and accumulators; instantiates dstf_divider. Uses dstf_pkg.
//
// channel   direction  handshake                    payload
// s_axis    in         i_s_axis_tvalid/o_..._tready tdata[0] solution_bit, tlast last_bit
// m_axis    out        o_m_axis_tvalid/i_..._tready tdata fitness_fraction, raw_score, status
// cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index register, i_cfg_data value
//
// A word that closes no trap and is not last leaves the unit ready for the next word. A word
// that closes a trap starts the step division on the shared divider and waits in S_SCORE.
// The last word then runs the step division (when it closes a trap), the trap maximum
// division and the long division in turn; a bad status skips the long division.
// Reset is synchronous; the result sits in an output register, so input is taken
// again while it waits; a stalled result only holds up the next last word.
`default_nettype none

module deceptive_step_trap_fitness_unit
    import dstf_pkg::*;
#(
    parameter int MAX_SOLUTION_BITS = DEF_MAX_SOLUTION_BITS,
    parameter int FRACTION_BITS     = DEF_FRACTION_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,  // [0] solution_bit
    input  wire logic                   i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] o_m_axis_tdata, // [16:0] fitness_fraction,
                                                         // [33:17] raw_score, [35:34] status
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int BS_W  = $clog2(MAX_SOLUTION_BITS + 2);
    localparam int DEN_W = BS_W + TRAP_W;
    localparam int NUM_W = SUM_W + TRAP_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [BS_W-1:0] MAX_BITS  = BS_W'(MAX_SOLUTION_BITS);
    localparam logic [BS_W-1:0] OVER_BITS = BS_W'(MAX_SOLUTION_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCORE,
        S_TMAX,
        S_MUL,
        S_BIG,
        S_OUT
    } t_state;

    t_state r_state;
    logic [TRAP_W-1:0] r_trap_bits;
    logic [OFS_W-1:0]  r_step_offset;
    logic [STEP_W-1:0] r_step_width;
    logic [TRAP_W-1:0] r_bits_in_trap;
    logic [TRAP_W-1:0] r_ones_in_trap;
    logic [SUM_W-1:0]  r_score_sum;
    logic [BS_W-1:0]   r_bits_seen;
    logic              r_last;
    t_status           r_status;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [FRAC_W-1:0] r_frac;
    logic              r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [TRAP_W-1:0] w_t;
    logic [STEP_W-1:0] w_sw;
    logic              w_accept;
    logic              w_take;
    logic [TRAP_W-1:0] n_bits_in_trap;
    logic [TRAP_W-1:0] n_ones_in_trap;
    logic [TRAP_W-1:0] w_score;
    logic [TRAP_W-1:0] w_small_num;
    logic [TRAP_W-1:0] w_tmax_num;
    logic              w_trap_done;
    logic [SUM_W:0]    w_sum_ext;
    logic              w_len_bad;
    logic              w_out_free;
    logic [SUM_W+TRAP_W-1:0] w_sum_t;
    logic [DEN_W-1:0]  w_len_t;

    logic              w_div_start;
    logic [NUM_W-1:0]  w_div_num;
    logic [DEN_W-1:0]  w_div_den;
    logic [CNT_W-1:0]  w_div_iters;
    logic [NUM_W-1:0]  w_quot;
    t_div_stat         w_div_stat;

    assign w_t  = clamp_1_16(r_trap_bits);
    assign w_sw = clamp_1_16(r_step_width);

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_take          = r_bits_seen < MAX_BITS;

    assign n_bits_in_trap = r_bits_in_trap + TRAP_W'(1);
    assign n_ones_in_trap = r_ones_in_trap + TRAP_W'(i_s_axis_tdata[0]);
    assign w_trap_done    = w_take && (n_bits_in_trap >= w_t);
    assign w_score        = (n_ones_in_trap >= w_t) ? w_t
                                                    : w_t - n_ones_in_trap - TRAP_W'(1);
    assign w_small_num    = TRAP_W'(r_step_offset) + w_score;
    assign w_tmax_num     = TRAP_W'(r_step_offset) + w_t;
    assign w_sum_ext      = {1'b0, r_score_sum} + (SUM_W + 1)'(w_quot[TRAP_W-1:0]);
    assign w_len_bad      = (r_bits_seen > MAX_BITS) || (r_bits_in_trap != '0);
    assign w_out_free     = !r_out_valid || i_m_axis_tready;
    assign w_sum_t        = (SUM_W + TRAP_W)'(r_score_sum) * (SUM_W + TRAP_W)'(w_t);
    assign w_len_t        = DEN_W'(r_bits_seen) * DEN_W'(w_quot[TRAP_W-1:0]);

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = DEN_W'(w_sw);
        w_div_iters = CNT_W'(TRAP_W);
        case (r_state)
            S_IDLE: begin
                w_div_start = w_accept && w_trap_done;
                w_div_num   = {w_small_num, {(NUM_W-TRAP_W){1'b0}}};
            end
            S_SCORE: begin
                w_div_start = r_last && (w_div_stat.done || !w_div_stat.busy);
                w_div_num   = {w_tmax_num, {(NUM_W-TRAP_W){1'b0}}};
            end
            S_MUL: begin
                w_div_start = 1'b1;
                w_div_num   = r_num;
                w_div_den   = r_den;
                w_div_iters = CNT_W'(NUM_W);
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    dstf_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_iters (w_div_iters),
        .o_quot  (w_quot),
        .o_stat  (w_div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_trap_bits    <= RST_TRAP_BITS;
            r_step_offset  <= RST_STEP_OFFSET;
            r_step_width   <= RST_STEP_WIDTH;
            r_bits_in_trap <= '0;
            r_ones_in_trap <= '0;
            r_score_sum    <= '0;
            r_bits_seen    <= '0;
            r_last         <= 1'b0;
            r_status       <= ST_OK;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_TRAP_BITS:   r_trap_bits   <= i_cfg_data;
                    REG_STEP_OFFSET: r_step_offset <= i_cfg_data[OFS_W-1:0];
                    REG_STEP_WIDTH:  r_step_width  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_axis_tready && r_state != S_OUT) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last <= i_s_axis_tlast;
                        if (w_take) begin
                            r_bits_seen <= r_bits_seen + BS_W'(1);
                            if (w_trap_done) begin
                                r_bits_in_trap <= '0;
                                r_ones_in_trap <= '0;
                            end else begin
                                r_bits_in_trap <= n_bits_in_trap;
                                r_ones_in_trap <= n_ones_in_trap;
                            end
                        end else begin
                            r_bits_seen <= OVER_BITS;
                        end
                        if (w_trap_done) r_state <= S_SCORE;
                        else if (i_s_axis_tlast) r_state <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    // entered without a division only for a last word closing no trap
                    if (w_div_stat.done || !w_div_stat.busy) begin
                        if (w_div_stat.done) begin
                            r_score_sum <= w_sum_ext[SUM_W] ? SUM_SAT : w_sum_ext[SUM_W-1:0];
                        end
                        if (r_last) r_state <= S_TMAX;
                        else r_state <= S_IDLE;
                    end
                end
                S_TMAX: begin
                    if (!w_div_stat.busy && !w_div_stat.done && !r_last) begin
                        r_state <= S_IDLE;
                    end else if (w_div_stat.done) begin
                        r_num <= {w_sum_t, {FRACTION_BITS{1'b0}}};
                        r_den <= w_len_t;
                        r_frac <= '0;
                        if (w_len_bad) begin
                            r_status <= ST_LENGTH;
                            r_state  <= S_OUT;
                        end else if (w_quot[TRAP_W-1:0] == '0) begin
                            r_status <= ST_ZERO_MAX;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_MUL;
                        end
                    end else if (!w_div_stat.busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_state <= S_BIG;
                end
                S_BIG: begin
                    if (w_div_stat.done) begin
                        r_frac  <= (|w_quot[NUM_W-1:FRAC_W]) ? FRAC_SAT
                                                             : w_quot[FRAC_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_bits_in_trap <= '0;
                        r_ones_in_trap <= '0;
                        r_score_sum    <= '0;
                        r_bits_seen    <= '0;
                        r_last         <= 1'b0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_data <= {{(OUT_TDATA_W-FRAC_W-SUM_W-STATUS_W){1'b0}},
                           r_status, r_score_sum, r_frac};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> !o_s_axis_tready)
        else $error("input taken while divider busy");
    a_trap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_in_trap <= TRAP_MAX_SIZE)
        else $error("trap bit count out of range");
    a_ones_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ones_in_trap <= r_bits_in_trap)
        else $error("more ones than bits in trap");
    a_done_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_SCORE || r_state == S_TMAX || r_state == S_BIG))
        else $error("divider finished in unexpected state");
    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_bits_seen == '0 && r_score_sum == '0))
        else $error("solution state not cleared after result");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_deceptive_step_trap_fitness_unit.sv =====
// tb_deceptive_step_trap_fitness_unit: self-checking bench for the step trap fitness unit.
// Directed table, then random solutions over several register settings; uses dstf_pkg and
// deceptive_step_trap_fitness_unit.
`default_nettype none

module tb_deceptive_step_trap_fitness_unit;
    import dstf_pkg::*;

    localparam int MAX_BITS      = DEF_MAX_SOLUTION_BITS;
    localparam int FRACTION_BITS = DEF_FRACTION_BITS;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_WORDS   = 45;
    localparam int PHASE_SOLS    = 4;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [FRAC_W-1:0] fraction;
        logic [SUM_W-1:0]  raw;
        t_status           status;
    } t_fitness;

    typedef enum logic {
        ROW_REG,
        ROW_WORD
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  sol_bit;
        logic                  last;
        logic                  typed;
        t_fitness              want;
    } t_row;

    localparam t_fitness NO_FIT = '0;

    localparam t_row DIRECTED [37] = '{
        // plain 5-bit trap after reset: full trap, empty trap, short solution
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b1, 1'b1, '{17'd65536, 17'd5, ST_OK}},
        '{ROW_WORD, 2'd0, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b0, 1'b1, 1'b1, '{17'd52428, 17'd4, ST_OK}},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b1, 1'b1, '{17'd0, 17'd0, ST_LENGTH}},
        // zero sizes act as one, max offset, write to the unused index
        '{ROW_REG, REG_TRAP_BITS, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_REG, REG_STEP_WIDTH, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_REG, REG_STEP_OFFSET, 5'd15, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_REG, REG_UNUSED, 5'd31, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b1, 1'b1, '{17'd65536, 17'd16, ST_OK}},
        '{ROW_WORD, 2'd0, 5'd0, 1'b0, 1'b1, 1'b1, '{17'd61440, 17'd15, ST_OK}},
        // zero trap maximum
        '{ROW_REG, REG_TRAP_BITS, 5'd1, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_REG, REG_STEP_OFFSET, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_REG, REG_STEP_WIDTH, 5'd2, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b1, 1'b1, '{17'd0, 17'd0, ST_ZERO_MAX}},
        // short solution beats zero maximum; oversized step width
        '{ROW_REG, REG_TRAP_BITS, 5'd2, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_REG, REG_STEP_WIDTH, 5'd31, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b1, 1'b1, '{17'd0, 17'd0, ST_LENGTH}},
        // offset bit 4 is dropped
        '{ROW_REG, REG_STEP_OFFSET, 5'd31, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b1, 1'b1, '{17'd65536, 17'd1, ST_OK}},
        '{ROW_WORD, 2'd0, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b1, 1'b1, '{17'd0, 17'd0, ST_OK}},
        '{ROW_REG, REG_TRAP_BITS, 5'd3, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_REG, REG_STEP_OFFSET, 5'd7, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_REG, REG_STEP_WIDTH, 5'd5, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b0, 1'b0, 1'b0, NO_FIT},
        '{ROW_WORD, 2'd0, 5'd0, 1'b1, 1'b1, 1'b0, NO_FIT}
    };

    logic                   i_clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_cfg_ready;

    // predictor copy of registers and per-solution state
    logic [TRAP_W-1:0] trap_reg   = RST_TRAP_BITS;
    logic [OFS_W-1:0]  offset_reg = RST_STEP_OFFSET;
    logic [STEP_W-1:0] step_reg   = RST_STEP_WIDTH;
    logic [4:0]        bits_in_trap = '0;
    logic [4:0]        ones_in_trap = '0;
    logic [SUM_W-1:0]  score_sum    = '0;
    logic [12:0]       bits_seen    = '0;

    t_fitness fitness_q[$];
    int       errors        = 0;
    int       cycle_count   = 0;
    int       words_sent    = 0;
    int       src_idle_pct  = 0;
    int       sink_idle_pct = 0;

    deceptive_step_trap_fitness_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int clamp_size(input logic [4:0] v);
        int r;
        r = int'(v);
        if (r < 1) r = 1;
        if (r > 16) r = 16;
        return r;
    endfunction

    task automatic note_error(input string msg);
        if (errors < REPORT_LIMIT) $display("%s", msg);
        errors++;
    endtask

    // score one solution bit; a last bit yields the fitness word
    task automatic score_bit(input logic b, input logic l, output logic has_fit,
                             output t_fitness fit);
        int t, sw, score, sum_next, trap_max;
        longint unsigned num, den, frac;
        t = clamp_size(trap_reg);
        sw = clamp_size(step_reg);
        has_fit = 1'b0;
        fit = NO_FIT;
        if (int'(bits_seen) < MAX_BITS) begin
            bits_seen++;
            bits_in_trap++;
            ones_in_trap += 5'(b);
            if (int'(bits_in_trap) >= t) begin
                if (int'(ones_in_trap) >= t) score = t;
                else score = t - int'(ones_in_trap) - 1;
                sum_next = int'(score_sum) + (int'(offset_reg) + score) / sw;
                if (sum_next > int'(SUM_SAT)) sum_next = int'(SUM_SAT);
                score_sum = SUM_W'(sum_next);
                bits_in_trap = '0;
                ones_in_trap = '0;
            end
        end else begin
            bits_seen = 13'(MAX_BITS + 1);
        end
        if (l) begin
            has_fit = 1'b1;
            trap_max = (int'(offset_reg) + t) / sw;
            fit.raw = score_sum;
            if (int'(bits_seen) > MAX_BITS || bits_in_trap != 0) begin
                fit.status = ST_LENGTH;
            end else if (trap_max == 0) begin
                fit.status = ST_ZERO_MAX;
            end else begin
                fit.status = ST_OK;
                num = (longint'(score_sum) * longint'(t)) << FRACTION_BITS;
                den = longint'(bits_seen) * longint'(trap_max);
                frac = (den != 0) ? num / den : 0;
                if (frac > longint'(FRAC_SAT)) frac = longint'(FRAC_SAT);
                fit.fraction = FRAC_W'(frac);
            end
            bits_in_trap = '0;
            ones_in_trap = '0;
            score_sum = '0;
            bits_seen = '0;
        end
    endtask

    task automatic send_word(input logic b, input logic l, input logic typed,
                             input t_fitness want);
        logic     has_fit;
        t_fitness fit;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= IN_TDATA_W'(b);
        s_tlast <= l;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        words_sent++;
        score_bit(b, l, has_fit, fit);
        if (has_fit) fitness_q.insert(fitness_q.size(), typed ? want : fit);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_TRAP_BITS:   trap_reg = val;
            REG_STEP_OFFSET: offset_reg = val[OFS_W-1:0];
            REG_STEP_WIDTH:  step_reg = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // let every fitness word drain, then give the divider time to go quiet
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (fitness_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                src_idle_pct = 19;
                sink_idle_pct = 49;
            end
            1: begin
                src_idle_pct = 49;
                sink_idle_pct = 19;
            end
            default: begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
        endcase
    endtask

    // traps are mostly full, empty, one short of full, or random
    task automatic send_solution(input int len);
        int   t, pattern, hole;
        logic b;
        t = clamp_size(trap_reg);
        pattern = 0;
        hole = 0;
        for (int i = 0; i < len; i++) begin
            if (i % t == 0) begin
                pattern = $urandom_range(3);
                hole = $urandom_range(t - 1);
            end
            case (pattern)
                0:       b = 1'b1;
                1:       b = 1'b0;
                2:       b = 1'($urandom_range(1));
                default: b = ((i % t) != hole);
            endcase
            send_word(b, i == len - 1, 1'b0, NO_FIT);
        end
    endtask

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin : check_fitness
        t_fitness got, want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            got.fraction = o_m_axis_tdata[FRAC_W-1:0];
            got.raw = o_m_axis_tdata[FRAC_W+SUM_W-1:FRAC_W];
            got.status = t_status'(o_m_axis_tdata[FRAC_W+SUM_W+STATUS_W-1:FRAC_W+SUM_W]);
            if (fitness_q.size() == 0) begin
                note_error($sformatf("unexpected fitness word: frac %0d raw %0d status %0d",
                                     got.fraction, got.raw, got.status));
            end else begin
                want = fitness_q.pop_front();
                if (got.fraction !== want.fraction || got.raw !== want.raw ||
                    got.status !== want.status)
                    note_error($sformatf(
                        "fitness mismatch: want frac %0d raw %0d status %0d, got %0d %0d %0d",
                        want.fraction, want.raw, want.status,
                        got.fraction, got.raw, got.status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        int                    phase_start, sols, len, t;
        logic [CFG_DATA_W-1:0] trap_v, ofs_v, step_v;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        set_idle(0);
        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].kind == ROW_REG) begin
                wait_idle();
                cfg_write(DIRECTED[k].idx, DIRECTED[k].data);
            end else begin
                send_word(DIRECTED[k].sol_bit, DIRECTED[k].last, DIRECTED[k].typed,
                          DIRECTED[k].want);
            end
        end
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_idle(p / 4);
            case (p)
                0: begin
                    trap_v = 5'd5; ofs_v = 5'd0; step_v = 5'd1;
                end
                1: begin
                    trap_v = 5'd16; ofs_v = 5'd15; step_v = 5'd1;
                end
                2: begin
                    trap_v = 5'd1; ofs_v = 5'd0; step_v = 5'd16;
                end
                3: begin
                    trap_v = 5'd16; ofs_v = 5'd0; step_v = 5'd16;
                end
                RAND_PHASES - 1: begin
                    trap_v = 5'd31; ofs_v = 5'd31; step_v = 5'd31;
                end
                default: begin
                    trap_v = 5'($urandom_range(31));
                    ofs_v = 5'($urandom_range(31));
                    step_v = 5'($urandom_range(31));
                end
            endcase
            cfg_write(REG_TRAP_BITS, trap_v);
            cfg_write(REG_STEP_OFFSET, ofs_v);
            cfg_write(REG_STEP_WIDTH, step_v);

            t = clamp_size(trap_reg);
            phase_start = words_sent;
            sols = 0;
            while (words_sent - phase_start < PHASE_WORDS || sols < PHASE_SOLS) begin
                if ($urandom_range(99) < 85) len = t * $urandom_range(1, 3);
                else len = $urandom_range(1, 2 * t + 2);
                send_solution(len);
                sols++;
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
